// ===== sv/tfa_pkg.sv =====
package tfa_pkg;

   localparam int unsigned MAX_SEQUENCE = 16;
   localparam int unsigned POS_W        = 4;
   localparam int unsigned TILE_W       = 4;
   localparam int unsigned TIME_W       = 16;
   localparam int unsigned LEN_W        = 5;
   localparam int unsigned PASS_W       = 8;
   localparam int unsigned CSR_IDX_W    = 3;
   localparam int unsigned CSR_DATA_W   = 16;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DWELL_TICKS     = 3'd0,
      CSR_SEQUENCE_LENGTH = 3'd1,
      CSR_REPEAT_LIMIT    = 3'd2,
      CSR_START_POSITION  = 3'd3,
      CSR_IDENTITY_ORDER  = 3'd4
   } csr_index_type;

   localparam logic [TIME_W-1:0] DWELL_TICKS_RESET     = 16'd1;
   localparam logic [LEN_W-1:0]  SEQUENCE_LENGTH_RESET = 5'd16;
   localparam logic [LEN_W-1:0]  SEQUENCE_LENGTH_MAX   = LEN_W'(MAX_SEQUENCE);

endpackage

// ===== sv/tile_frame_animator.sv =====
// Sprite frame animator. Each item is a time tick, a write into the 16-entry frame order
// table, or a restart; every item gives exactly one result with the tile shown afterwards
// and the advance, repeat and finish events that it caused. A tick subtracts its elapsed
// count from the frame countdown and steps to the next position when the countdown runs
// out; wrapping past the sequence end counts a pass, and reaching a nonzero repeat limit
// stops the animation until a restart. One item is taken every clock cycle: the new
// state and the result are formed in combinational logic and held in the result register,
// so an item is accepted whenever that register is empty or its result is being taken.
// The result is valid in the cycle after acceptance. Configuration writes take effect
// at the next use and must be made while no result is outstanding.
module tile_frame_animator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_cmd,
   input  logic [tfa_pkg::TIME_W-1:0]         req_elapsed,
   input  logic [tfa_pkg::POS_W-1:0]          req_entry_index,
   input  logic [tfa_pkg::TILE_W-1:0]         req_entry_tile,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tfa_pkg::TILE_W-1:0]         rsp_tile_index,
   output logic                               rsp_frame_advanced,
   output logic                               rsp_repeat_event,
   output logic                               rsp_finish_event,
   output logic                               rsp_is_finished,
   input  logic                               csr_write_en,
   input  logic [tfa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tfa_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tfa_pkg::*;

   // configuration
   logic [TIME_W-1:0] dwell_ticks_ff;
   logic [LEN_W-1:0]  sequence_length_ff;
   logic [PASS_W-1:0] repeat_limit_ff;
   logic [POS_W-1:0]  start_position_ff;
   logic              identity_order_ff;

   // animation state; countdown always lies in 1..65535 between items
   logic [TIME_W-1:0] countdown_ff, countdown_in;
   logic [POS_W-1:0]  position_ff, position_in;
   logic [PASS_W-1:0] passes_ff, passes_in;
   logic              stopped_ff, stopped_in;
   logic [TILE_W-1:0] order_ff [MAX_SEQUENCE];
   logic [TILE_W-1:0] order_in [MAX_SEQUENCE];

   // result register
   logic              rsp_valid_ff;
   logic [TILE_W-1:0] rsp_tile_ff, tile_in;
   logic              rsp_adv_ff, adv_in;
   logic              rsp_rep_ff, rep_in;
   logic              rsp_fin_ff, fin_in;
   logic              rsp_stop_ff;

   logic              req_fire;
   logic [TIME_W-1:0] eff_dwell_ticks;
   logic [LEN_W-1:0]  eff_length;
   logic [POS_W-1:0]  restart_position;
   logic [POS_W-1:0]  pos_inc;
   logic              pos_wrap;
   logic [PASS_W-1:0] passes_inc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ticks_ff     <= DWELL_TICKS_RESET;
         sequence_length_ff <= SEQUENCE_LENGTH_RESET;
         repeat_limit_ff    <= '0;
         start_position_ff  <= '0;
         identity_order_ff  <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_DWELL_TICKS:     dwell_ticks_ff     <= csr_wdata[TIME_W-1:0];
            CSR_SEQUENCE_LENGTH: sequence_length_ff <= csr_wdata[LEN_W-1:0];
            CSR_REPEAT_LIMIT:    repeat_limit_ff    <= csr_wdata[PASS_W-1:0];
            CSR_START_POSITION:  start_position_ff  <= csr_wdata[POS_W-1:0];
            CSR_IDENTITY_ORDER:  identity_order_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      eff_dwell_ticks = (dwell_ticks_ff == '0) ? TIME_W'(1) : dwell_ticks_ff;
      if (sequence_length_ff == '0) begin
         eff_length = LEN_W'(1);
      end else if (sequence_length_ff > SEQUENCE_LENGTH_MAX) begin
         eff_length = SEQUENCE_LENGTH_MAX;
      end else begin
         eff_length = sequence_length_ff;
      end
      restart_position = ({1'b0, start_position_ff} < eff_length) ? start_position_ff : '0;
      pos_inc    = position_ff + POS_W'(1);
      // also wraps when the length has shrunk below the position
      pos_wrap   = (pos_inc == '0) || ({1'b0, pos_inc} >= eff_length);
      passes_inc = passes_ff + PASS_W'(1);
   end

   always_comb begin
      countdown_in = countdown_ff;
      position_in  = position_ff;
      passes_in    = passes_ff;
      stopped_in   = stopped_ff;
      order_in     = order_ff;
      adv_in       = 1'b0;
      rep_in       = 1'b0;
      fin_in       = 1'b0;
      unique case (req_cmd)
         CMD_TICK: begin
            if (!stopped_ff) begin
               if (req_elapsed >= countdown_ff) begin
                  adv_in       = 1'b1;
                  countdown_in = eff_dwell_ticks;
                  if (pos_wrap) begin
                     position_in = '0;
                     passes_in   = passes_inc;
                     if (repeat_limit_ff != '0 && repeat_limit_ff == passes_inc) begin
                        stopped_in = 1'b1;
                        fin_in     = 1'b1;
                     end else begin
                        rep_in = 1'b1;
                     end
                  end else begin
                     position_in = pos_inc;
                  end
               end else begin
                  countdown_in = countdown_ff - req_elapsed;
               end
            end
         end
         CMD_WRITE: begin
            order_in[req_entry_index] = req_entry_tile;
         end
         CMD_RESTART: begin
            countdown_in = eff_dwell_ticks;
            position_in  = restart_position;
            passes_in    = '0;
            stopped_in   = 1'b0;
         end
         default: ;
      endcase
      // write forwarded so the result sees the table after this item
      tile_in = identity_order_ff ? position_in : order_in[position_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= TIME_W'(1);
         position_ff  <= '0;
         passes_ff    <= '0;
         stopped_ff   <= 1'b0;
         for (int i = 0; i < MAX_SEQUENCE; i++) begin
            order_ff[i] <= '0;
         end
      end else if (req_fire) begin
         countdown_ff <= countdown_in;
         position_ff  <= position_in;
         passes_ff    <= passes_in;
         stopped_ff   <= stopped_in;
         order_ff     <= order_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_tile_ff <= tile_in;
         rsp_adv_ff  <= adv_in;
         rsp_rep_ff  <= rep_in;
         rsp_fin_ff  <= fin_in;
         rsp_stop_ff <= stopped_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tile_index     = rsp_tile_ff;
   assign rsp_frame_advanced = rsp_adv_ff;
   assign rsp_repeat_event   = rsp_rep_ff;
   assign rsp_finish_event   = rsp_fin_ff;
   assign rsp_is_finished    = rsp_stop_ff;

   a_finish_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fin_ff |-> rsp_stop_ff && rsp_adv_ff)
      else $error("finish event without stop");

   a_repeat_needs_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_rep_ff |-> rsp_adv_ff && !rsp_fin_ff && !rsp_stop_ff)
      else $error("repeat event inconsistent");

   a_stopped_tick_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_cmd == CMD_TICK && stopped_ff
      |=> stopped_ff && !rsp_adv_ff && $stable(position_ff))
      else $error("tick moved a stopped animation");

   a_countdown_nonzero: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> countdown_ff != '0)
      else $error("countdown left at zero");

endmodule
